FILE: rtl/fixed_point_conv_layer_assert.svh
// Assertion macros used by the checker file.
`ifndef FIXED_POINT_CONV_LAYER_ASSERT_SVH
`define FIXED_POINT_CONV_LAYER_ASSERT_SVH

// Same-cycle implication, reset masked.
`define FPCL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masked.
`define FPCL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/fpcl_pkg.sv
// Shared constants, codes and types of the fixed-point convolution layer.
`default_nettype none
package fpcl_pkg;
    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS    = 8;
    localparam int STRIDE       = 1;
    localparam int INPUT_WORDS  = 4096;
    localparam int WEIGHT_WORDS = 16384;
    localparam int OUTPUT_WORDS = 4096;
    localparam int BIAS_WORDS   = 64;
    localparam int ACC_W        = 48;
    localparam int PROD_W       = 2 * DATA_WIDTH;

    localparam int IN_AW  = $clog2(INPUT_WORDS);
    localparam int WT_AW  = $clog2(WEIGHT_WORDS);
    localparam int OUT_AW = $clog2(OUTPUT_WORDS);
    localparam int B_AW   = $clog2(BIAS_WORDS);

    typedef enum logic [2:0] {
        FUNC_LOAD_IN   = 3'd0,
        FUNC_LOAD_WT   = 3'd1,
        FUNC_LOAD_BIAS = 3'd2,
        FUNC_START     = 3'd3,
        FUNC_READ      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        STATUS_READ = 2'd0,
        STATUS_DONE = 2'd1,
        STATUS_SIZE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_IN_CH  = 3'd0,
        CFG_IN_H   = 3'd1,
        CFG_IN_W   = 3'd2,
        CFG_OUT_CH = 3'd3,
        CFG_OUT_H  = 3'd4,
        CFG_OUT_W  = 3'd5,
        CFG_K_H    = 3'd6,
        CFG_K_W    = 3'd7
    } t_cfg_idx;

    // Commands to the shared multiply-accumulate unit.
    typedef struct packed {
        logic init;   // acc = bias << FRAC_BITS
        logic mul;    // prod = a * b
        logic add;    // acc += prod
        logic sat;    // acc = sat(acc >> FRAC_BITS) << FRAC_BITS
    } t_mac_ctrl;
endpackage
`default_nettype wire

FILE: rtl/fixed_point_conv_layer.sv
// Top level of the fixed-point multi-channel 2-D convolution layer.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | i_valid/o_ready, i_func, i_address, i_value | in
//  result  | o_valid/i_ready, o_status, o_read_value    | out
//  config  | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
//
//  A load writes its store when accepted; a read registers the stored word and
//  then the result. A start runs the size checks, then for each output plane
//  fetches the bias and, per output word, multiplies and accumulates every
//  in-range tap of each input plane, skips padded taps, saturates per plane.
//  While a result waits in the output register no request is taken.
//  Reset (synchronous, active low) clears control state, config and the MAC accumulator.
`default_nettype none
module fixed_point_conv_layer (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // request channel
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [2:0]                             i_func,
    input  wire logic [13:0]                            i_address,
    input  wire logic signed [fpcl_pkg::DATA_WIDTH-1:0] i_value,
    // result channel
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic [1:0]                                  o_status,
    output logic signed [fpcl_pkg::DATA_WIDTH-1:0]      o_read_value,
    // configuration channel
    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic [2:0]                             i_cfg_index,
    input  wire logic [6:0]                             i_cfg_data
);
    import fpcl_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_READ, S_CHK1, S_CHK2, S_PO, S_BIAS, S_PIX, S_PLANE,
        S_ROW, S_TAP, S_MUL, S_ACC, S_SAT, S_WR
    } t_state;

    // ---------------- configuration registers ----------------
    logic [6:0] r_ic, r_ih, r_iw, r_oc, r_oh, r_ow;
    logic [2:0] r_kh, r_kw;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ic <= 7'd1; r_ih <= 7'd1; r_iw <= 7'd1;
            r_oc <= 7'd1; r_oh <= 7'd1; r_ow <= 7'd1;
            r_kh <= 3'd3; r_kw <= 3'd3;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IN_CH:  r_ic <= i_cfg_data;
                CFG_IN_H:   r_ih <= i_cfg_data;
                CFG_IN_W:   r_iw <= i_cfg_data;
                CFG_OUT_CH: r_oc <= i_cfg_data;
                CFG_OUT_H:  r_oh <= i_cfg_data;
                CFG_OUT_W:  r_ow <= i_cfg_data;
                CFG_K_H:    r_kh <= i_cfg_data[2:0];
                CFG_K_W:    r_kw <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer registers ----------------
    t_state      r_state;
    logic        r_out_valid;
    logic [1:0]  r_status;
    logic signed [DATA_WIDTH-1:0] r_out_value;
    logic        r_rd_oob;

    // size check partial products
    logic [13:0] r_p1, r_p2, r_p3, r_plane;
    logic [5:0]  r_khw;
    logic [12:0] r_nwk;

    // loop counters and running addresses
    logic [6:0]  r_po, r_ho, r_wo, r_pi;
    logic [2:0]  r_hk, r_wk;
    logic [12:0] r_in_base, r_row_addr, r_oi;
    logic [14:0] r_wi, r_wpo;
    logic signed [DATA_WIDTH-1:0] r_bias;

    logic accept;
    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign accept  = i_valid && o_ready;

    // ---------------- stores ----------------
    logic signed [DATA_WIDTH-1:0] input_store  [INPUT_WORDS];
    logic signed [DATA_WIDTH-1:0] weight_store [WEIGHT_WORDS];
    logic signed [DATA_WIDTH-1:0] bias_store   [BIAS_WORDS];
    logic signed [DATA_WIDTH-1:0] output_store [OUTPUT_WORDS];

    logic signed [DATA_WIDTH-1:0] r_in_q, r_wt_q, r_bias_q, r_out_q;
    logic signed [DATA_WIDTH-1:0] mac_result;

    logic            tap_rd;
    logic [IN_AW-1:0] tap_in_addr;

    // tap position arithmetic
    logic [2:0]         pad;
    logic signed [10:0] hin, win;
    logic               hin_ok, win_ok;
    logic [13:0]        row_prod;
    logic [20:0]        nin, nout;
    logic [19:0]        nw;
    logic               size_bad;

    assign pad = r_kh >> 1;
    assign hin = $signed({1'b0, 10'(r_ho * STRIDE)}) + $signed({8'b0, r_hk})
               - $signed({8'b0, pad});
    assign win = $signed({1'b0, 10'(r_wo * STRIDE)}) + $signed({8'b0, r_wk})
               - $signed({8'b0, pad});
    assign hin_ok = !hin[10] && (hin[9:0] < {3'b0, r_ih});
    assign win_ok = !win[10] && (win[9:0] < {3'b0, r_iw});
    assign row_prod = hin[6:0] * r_iw;

    assign tap_rd      = (r_state == S_TAP) && (r_wk != r_kw) && win_ok;
    assign tap_in_addr = IN_AW'(r_row_addr + 13'(win[6:0]));

    assign nin  = 21'(r_p1 * r_iw);
    assign nw   = 20'(r_p2 * r_khw);
    assign nout = 21'(r_p3 * r_ow);
    assign size_bad = (nin > 21'(INPUT_WORDS)) || (nw > 20'(WEIGHT_WORDS))
                   || (nout > 21'(OUTPUT_WORDS)) || (r_oc > 7'(BIAS_WORDS));

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FUNC_LOAD_IN && i_address < 14'(INPUT_WORDS)) begin
            input_store[i_address[IN_AW-1:0]] <= i_value;
        end
        if (tap_rd) begin
            r_in_q <= input_store[tap_in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FUNC_LOAD_WT
                && {1'b0, i_address} < 15'(WEIGHT_WORDS)) begin
            weight_store[i_address[WT_AW-1:0]] <= i_value;
        end
        if (tap_rd) begin
            r_wt_q <= weight_store[r_wi[WT_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && t_func'(i_func) == FUNC_LOAD_BIAS && i_address < 14'(BIAS_WORDS)) begin
            bias_store[i_address[B_AW-1:0]] <= i_value;
        end
        if (r_state == S_PO) begin
            r_bias_q <= bias_store[r_po[B_AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_WR) begin
            output_store[r_oi[OUT_AW-1:0]] <= mac_result;
        end
        if (accept && t_func'(i_func) == FUNC_READ) begin
            r_out_q <= output_store[i_address[OUT_AW-1:0]];
        end
    end

    // ---------------- shared MAC ----------------
    t_mac_ctrl mac_ctrl;

    always_comb begin
        mac_ctrl      = '0;
        mac_ctrl.init = (r_state == S_PIX) && (r_ho != r_oh) && (r_wo != r_ow);
        mac_ctrl.mul  = (r_state == S_MUL);
        mac_ctrl.add  = (r_state == S_ACC);
        mac_ctrl.sat  = (r_state == S_SAT);
    end

    fpcl_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (mac_ctrl),
        .i_bias   (r_bias),
        .i_a      (r_in_q),
        .i_b      (r_wt_q),
        .o_result (mac_result)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_rd_oob <= i_address >= 14'(OUTPUT_WORDS);
                        priority case (t_func'(i_func))
                            FUNC_READ:  r_state <= S_READ;
                            FUNC_START: r_state <= S_CHK1;
                            default:    r_state <= S_IDLE;
                        endcase
                    end
                end
                S_READ: begin
                    r_out_valid <= 1'b1;
                    r_status    <= STATUS_READ;
                    r_out_value <= r_rd_oob ? '0 : r_out_q;
                    r_state     <= S_IDLE;
                end
                S_CHK1: begin
                    r_p1    <= 14'(r_ic * r_ih);
                    r_p2    <= 14'(r_oc * r_ic);
                    r_p3    <= 14'(r_oc * r_oh);
                    r_khw   <= 6'(r_kh * r_kw);
                    r_plane <= 14'(r_ih * r_iw);
                    r_state <= S_CHK2;
                end
                S_CHK2: begin
                    r_nwk <= 13'(r_ic * r_khw);
                    r_po  <= '0;
                    r_wpo <= '0;
                    r_oi  <= '0;
                    if (size_bad) begin
                        r_out_valid <= 1'b1;
                        r_status    <= STATUS_SIZE;
                        r_out_value <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_PO;
                    end
                end
                S_PO: begin
                    r_ho <= '0;
                    r_wo <= '0;
                    if (r_po == r_oc) begin
                        r_out_valid <= 1'b1;
                        r_status    <= STATUS_DONE;
                        r_out_value <= '0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    r_bias  <= r_bias_q;
                    r_state <= S_PIX;
                end
                S_PIX: begin
                    priority if (r_ho == r_oh) begin
                        r_po    <= r_po + 7'd1;
                        r_wpo   <= r_wpo + 15'(r_nwk);
                        r_state <= S_PO;
                    end else if (r_wo == r_ow) begin
                        r_wo <= '0;
                        r_ho <= r_ho + 7'd1;
                    end else begin
                        // accumulator loads bias here
                        r_pi      <= '0;
                        r_in_base <= '0;
                        r_wi      <= r_wpo;
                        r_state   <= S_PLANE;
                    end
                end
                S_PLANE: begin
                    r_hk <= '0;
                    r_state <= (r_pi == r_ic) ? S_WR : S_ROW;
                end
                S_ROW: begin
                    priority if (r_hk == r_kh) begin
                        r_state <= S_SAT;
                    end else if (!hin_ok) begin
                        // whole kernel row falls in the padding
                        r_wi <= r_wi + 15'(r_kw);
                        r_hk <= r_hk + 3'd1;
                    end else begin
                        r_row_addr <= 13'(r_in_base + 13'(row_prod));
                        r_wk       <= '0;
                        r_state    <= S_TAP;
                    end
                end
                S_TAP: begin
                    if (r_wk == r_kw) begin
                        r_hk    <= r_hk + 3'd1;
                        r_state <= S_ROW;
                    end else begin
                        r_wk <= r_wk + 3'd1;
                        r_wi <= r_wi + 15'd1;
                        if (win_ok) begin
                            r_state <= S_MUL;
                        end
                    end
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: r_state <= S_TAP;
                S_SAT: begin
                    r_pi      <= r_pi + 7'd1;
                    r_in_base <= 13'(r_in_base + 13'(r_plane));
                    r_state   <= S_PLANE;
                end
                S_WR: begin
                    r_oi    <= r_oi + 13'd1;
                    r_wo    <= r_wo + 7'd1;
                    r_state <= S_PIX;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid      = r_out_valid;
    assign o_status     = r_status;
    assign o_read_value = r_out_value;
endmodule
`default_nettype wire

FILE: rtl/fpcl_mac.sv
// Shared multiply-accumulate unit with per-plane saturation.
`default_nettype none
module fpcl_mac (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire fpcl_pkg::t_mac_ctrl                     i_ctrl,
    input  wire logic signed [fpcl_pkg::DATA_WIDTH-1:0]  i_bias,
    input  wire logic signed [fpcl_pkg::DATA_WIDTH-1:0]  i_a,
    input  wire logic signed [fpcl_pkg::DATA_WIDTH-1:0]  i_b,
    output logic signed [fpcl_pkg::DATA_WIDTH-1:0]       o_result
);
    import fpcl_pkg::*;

    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(64'sd1 <<< (DATA_WIDTH-1)));

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [ACC_W-1:0]  acc_shr;
    logic signed [ACC_W-1:0]  acc_sat;

    // Arithmetic shift rounds toward minus infinity.
    assign acc_shr = r_acc >>> FRAC_BITS;

    always_comb begin
        priority if (acc_shr > SAT_HI) begin
            acc_sat = SAT_HI;
        end else if (acc_shr < SAT_LO) begin
            acc_sat = SAT_LO;
        end else begin
            acc_sat = acc_shr;
        end
    end

    always_comb begin
        n_acc = r_acc;
        priority if (i_ctrl.init) begin
            n_acc = ACC_W'(i_bias) <<< FRAC_BITS;
        end else if (i_ctrl.add) begin
            n_acc = r_acc + ACC_W'(r_prod);
        end else if (i_ctrl.sat) begin
            n_acc = acc_sat <<< FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_result = acc_shr[DATA_WIDTH-1:0];
endmodule
`default_nettype wire

FILE: rtl/fpcl_checker.sv
// Port-level checker for the convolution layer, bound to the top level.
`default_nettype none
`include "fixed_point_conv_layer_assert.svh"
module fpcl_checker (
    input wire logic                                   i_clk,
    input wire logic                                   i_rst_n,
    input wire logic                                   i_valid,
    input wire logic                                   o_ready,
    input wire logic [2:0]                             i_func,
    input wire logic                                   o_valid,
    input wire logic                                   i_ready,
    input wire logic [1:0]                             o_status,
    input wire logic signed [fpcl_pkg::DATA_WIDTH-1:0] o_read_value
);
    import fpcl_pkg::*;

    logic req_load;
    assign req_load = i_valid && o_ready && (i_func == FUNC_LOAD_IN
                   || i_func == FUNC_LOAD_WT || i_func == FUNC_LOAD_BIAS);

    `FPCL_ASSERT_NEXT(a_out_hold, o_valid && !i_ready, o_valid && $stable(o_status) && $stable(o_read_value), "result changed while stalled")
    `FPCL_ASSERT_NOW(a_zero_value, o_valid && o_status != STATUS_READ, o_read_value == '0, "nonzero value on status result")
    `FPCL_ASSERT_NEXT(a_load_silent, req_load, !o_valid, "load produced a result")
    `FPCL_ASSERT_NOW(a_busy_result, o_valid, !o_ready, "request taken while result pending")
endmodule

bind fixed_point_conv_layer fpcl_checker u_fpcl_checker (.*);
`default_nettype wire
